>>> hdl/lpbf_pkg.sv
// ----------------------------------------------------------------------------
// lpbf_pkg
// Shared types and constants of the longest-path Bellman-Ford unit.
// ----------------------------------------------------------------------------
package lpbf_pkg;

  localparam int NODE_W   = 11;
  localparam int WEIGHT_W = 32;
  localparam int DIST_W   = 64;

  typedef struct packed {
    logic [NODE_W-1:0]          edge_source;
    logic [NODE_W-1:0]          edge_dest;
    logic signed [WEIGHT_W-1:0] edge_weight;
    logic                       last_edge;
  } lpbf_in_t;

  typedef struct packed {
    logic signed [DIST_W-1:0] longest_distance;
    logic                     target_reached;
    logic                     positive_cycle;
  } lpbf_out_t;

  typedef struct packed {
    logic [NODE_W-1:0]   src;
    logic [NODE_W-1:0]   dst;
    logic [WEIGHT_W-1:0] weight;
  } edge_rec_t;

  typedef struct packed {
    logic [DIST_W-1:0] dist_val;
    logic              reached;
    logic              on_cycle;
  } node_entry_t;

  typedef enum logic [3:0] {
    S_LOAD,
    S_CLEAR,
    S_EREAD,
    S_NREAD,
    S_ADD,
    S_WRITE,
    S_PEND,
    S_RREAD,
    S_RWAIT
  } lpbf_state_t;

endpackage

>>> hdl/lpbf_ram.sv
// ----------------------------------------------------------------------------
// lpbf_ram
// Generic RAM: one write port, two read ports with registered read data.
// ----------------------------------------------------------------------------
module lpbf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re_a,
  input  logic [AW-1:0]    raddr_a,
  output logic [WIDTH-1:0] rdata_a,
  input  logic             re_b,
  input  logic [AW-1:0]    raddr_b,
  output logic [WIDTH-1:0] rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re_a) begin
      rdata_a <= mem[raddr_a];
    end
    if (re_b) begin
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

>>> hdl/lpbf_relax.sv
// ----------------------------------------------------------------------------
// lpbf_relax
// Relaxation of one edge: decides whether the destination improves and
// builds the entry written back to the node store.
// ----------------------------------------------------------------------------
module lpbf_relax
  import lpbf_pkg::*;
(
  input  node_entry_t       ent_a,
  input  node_entry_t       ent_b,
  input  logic [DIST_W-1:0] sum,
  input  logic              mark,
  output node_entry_t       ent_new,
  output logic              improve
);

  always_comb begin
    improve = !ent_b.reached || ($signed(ent_b.dist_val) < $signed(sum));
    ent_new = ent_b;
    // A cycle mark travels along every usable edge during the marking passes.
    ent_new.on_cycle = ent_b.on_cycle | (mark & ent_a.on_cycle);
    if (improve) begin
      ent_new.dist_val = sum;
      ent_new.reached  = 1'b1;
      ent_new.on_cycle = ent_new.on_cycle | mark;
    end
  end

endmodule

>>> hdl/longest_path_bellman_ford_unit.sv
// ----------------------------------------------------------------------------
// longest_path_bellman_ford_unit
// Loads a directed weighted graph and reports the longest distance from
// node 1 to the highest node, with positive-cycle detection.
// ----------------------------------------------------------------------------
// Edges are taken one per cycle while loading and written to the edge RAM;
// edges beyond MAX_EDGES are dropped. The edge that carries last_edge starts
// the computation; no request is taken until the result is in the output
// register. The computation first clears the node RAM entry of each node in
// use, then runs relaxation passes over the stored edges: an edge with both
// endpoints in range and a reached source goes through edge read, node read,
// add and write back, one with an unreached source stops after the add, one
// with an endpoint out of range after the node read; each pass ends with a
// final edge read and a pending step. One read-modify-write path via the
// node RAM takes one edge at a time. Up to num_nodes-1 maximizing passes run,
// fewer if one changes nothing, then num_nodes marking passes, target readout.
module longest_path_bellman_ford_unit
  import lpbf_pkg::*;
#(
  parameter int MAX_NODES = 1024,
  parameter int MAX_EDGES = 4096
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  lpbf_in_t          in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output lpbf_out_t         out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [NODE_W-1:0] cfg_data
);

  localparam int EA_W = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int EC_W = $clog2(MAX_EDGES + 1);
  localparam int NA_W = $clog2(MAX_NODES);
  localparam int NC_W = $clog2(MAX_NODES + 1);

  lpbf_state_t state_r, state_nxt;
  logic [NODE_W-1:0] num_nodes_r;
  logic [EC_W-1:0]   ecount_r, ecount_nxt;
  logic [EC_W-1:0]   eidx_r, eidx_nxt;
  logic [NC_W-1:0]   n_r, n_nxt;
  logic [NC_W-1:0]   pass_r, pass_nxt;
  logic [NC_W-1:0]   clr_r, clr_nxt;
  logic              phase_r, phase_nxt;
  logic              changed_r, changed_nxt;
  logic [DIST_W-1:0] sum_r, sum_nxt;
  lpbf_out_t         out_r, out_nxt;
  logic              out_valid_r, out_valid_nxt;

  logic              edge_we, edge_re;
  edge_rec_t         edge_wdata, edge_rdata;
  logic              node_we, node_re_a, node_re_b;
  logic [NA_W-1:0]   node_waddr, node_raddr_a, node_raddr_b;
  node_entry_t       node_wdata, node_rdata_a, node_rdata_b;
  node_entry_t       relax_ent;
  logic              relax_improve;

  logic              in_acc;
  logic              slot_free;
  logic              edge_ok;
  logic [31:0]       n_sel;
  logic [31:0]       src_m1, dst_m1, tgt_m1, clr_w;

  lpbf_ram #(.WIDTH($bits(edge_rec_t)), .DEPTH(MAX_EDGES)) u_edge_ram (
    .clk     (clk),
    .we      (edge_we),
    .waddr   (ecount_r[EA_W-1:0]),
    .wdata   (edge_wdata),
    .re_a    (edge_re),
    .raddr_a (eidx_r[EA_W-1:0]),
    .rdata_a (edge_rdata),
    .re_b    (1'b0),
    .raddr_b ('0),
    .rdata_b ()
  );

  lpbf_ram #(.WIDTH($bits(node_entry_t)), .DEPTH(MAX_NODES)) u_node_ram (
    .clk     (clk),
    .we      (node_we),
    .waddr   (node_waddr),
    .wdata   (node_wdata),
    .re_a    (node_re_a),
    .raddr_a (node_raddr_a),
    .rdata_a (node_rdata_a),
    .re_b    (node_re_b),
    .raddr_b (node_raddr_b),
    .rdata_b (node_rdata_b)
  );

  lpbf_relax u_relax (
    .ent_a   (node_rdata_a),
    .ent_b   (node_rdata_b),
    .sum     (sum_r),
    .mark    (phase_r),
    .ent_new (relax_ent),
    .improve (relax_improve)
  );

  assign in_stall  = (state_r != S_LOAD);
  assign in_acc    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign slot_free = !out_valid_r || !out_stall;

  assign src_m1 = 32'(edge_rdata.src) - 32'd1;
  assign dst_m1 = 32'(edge_rdata.dst) - 32'd1;
  assign tgt_m1 = 32'(n_r) - 32'd1;
  assign clr_w  = 32'(clr_r);
  assign edge_ok = (edge_rdata.src != '0) && (32'(edge_rdata.src) <= 32'(n_r)) &&
                   (edge_rdata.dst != '0) && (32'(edge_rdata.dst) <= 32'(n_r));

  always_comb begin
    if (num_nodes_r == '0) begin
      n_sel = 32'd1;
    end else if (32'(num_nodes_r) > MAX_NODES) begin
      n_sel = MAX_NODES;
    end else begin
      n_sel = 32'(num_nodes_r);
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_LOAD: begin
        if (in_acc && in_data.last_edge) begin
          state_nxt = S_CLEAR;
        end
      end
      S_CLEAR: begin
        if (32'(clr_r) + 32'd1 == 32'(n_r)) begin
          state_nxt = S_EREAD;
        end
      end
      S_EREAD: state_nxt = (eidx_r == ecount_r) ? S_PEND : S_NREAD;
      S_NREAD: state_nxt = edge_ok ? S_ADD : S_EREAD;
      S_ADD:   state_nxt = node_rdata_a.reached ? S_WRITE : S_EREAD;
      S_WRITE: state_nxt = S_EREAD;
      S_PEND: begin
        if (phase_r && (32'(pass_r) + 32'd1 >= 32'(n_r))) begin
          state_nxt = S_RREAD;
        end else begin
          state_nxt = S_EREAD;
        end
      end
      S_RREAD: state_nxt = S_RWAIT;
      S_RWAIT: begin
        if (slot_free) begin
          state_nxt = S_LOAD;
        end
      end
      default: state_nxt = S_LOAD;
    endcase
  end

  // Datapath and memory controls.
  always_comb begin
    ecount_nxt    = ecount_r;
    eidx_nxt      = eidx_r;
    n_nxt         = n_r;
    pass_nxt      = pass_r;
    clr_nxt       = clr_r;
    phase_nxt     = phase_r;
    changed_nxt   = changed_r;
    sum_nxt       = sum_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && out_stall;
    edge_we       = 1'b0;
    edge_re       = 1'b0;
    edge_wdata    = '{src: in_data.edge_source, dst: in_data.edge_dest,
                      weight: in_data.edge_weight};
    node_we       = 1'b0;
    node_waddr    = dst_m1[NA_W-1:0];
    node_wdata    = relax_ent;
    node_re_a     = 1'b0;
    node_re_b     = 1'b0;
    node_raddr_a  = src_m1[NA_W-1:0];
    node_raddr_b  = dst_m1[NA_W-1:0];
    case (state_r)
      S_LOAD: begin
        if (in_acc) begin
          if (32'(ecount_r) < MAX_EDGES) begin
            edge_we    = 1'b1;
            ecount_nxt = ecount_r + 1'b1;
          end
          if (in_data.last_edge) begin
            n_nxt   = n_sel[NC_W-1:0];
            clr_nxt = '0;
          end
        end
      end
      S_CLEAR: begin
        node_we    = 1'b1;
        node_waddr = clr_w[NA_W-1:0];
        node_wdata = '{dist_val: '0, reached: (clr_r == '0), on_cycle: 1'b0};
        clr_nxt    = clr_r + 1'b1;
        eidx_nxt   = '0;
        pass_nxt   = '0;
        changed_nxt = 1'b0;
        // With a single node the maximizing passes are skipped.
        phase_nxt  = (n_r == NC_W'(1));
      end
      S_EREAD: begin
        edge_re = (eidx_r != ecount_r);
      end
      S_NREAD: begin
        if (edge_ok) begin
          node_re_a = 1'b1;
          node_re_b = 1'b1;
        end else begin
          eidx_nxt = eidx_r + 1'b1;
        end
      end
      S_ADD: begin
        sum_nxt = node_rdata_a.dist_val +
                  {{(DIST_W-WEIGHT_W){edge_rdata.weight[WEIGHT_W-1]}}, edge_rdata.weight};
        if (!node_rdata_a.reached) begin
          eidx_nxt = eidx_r + 1'b1;
        end
      end
      S_WRITE: begin
        node_we     = 1'b1;
        changed_nxt = changed_r | relax_improve;
        eidx_nxt    = eidx_r + 1'b1;
      end
      S_PEND: begin
        eidx_nxt    = '0;
        changed_nxt = 1'b0;
        if (!phase_r) begin
          if (!changed_r || (32'(pass_r) + 32'd2 >= 32'(n_r))) begin
            phase_nxt = 1'b1;
            pass_nxt  = '0;
          end else begin
            pass_nxt = pass_r + 1'b1;
          end
        end else begin
          pass_nxt = pass_r + 1'b1;
        end
      end
      S_RREAD: begin
        node_re_a    = 1'b1;
        node_raddr_a = tgt_m1[NA_W-1:0];
      end
      S_RWAIT: begin
        if (slot_free) begin
          out_valid_nxt           = 1'b1;
          out_nxt.target_reached  = node_rdata_a.reached;
          out_nxt.positive_cycle  = node_rdata_a.on_cycle;
          out_nxt.longest_distance = (node_rdata_a.reached && !node_rdata_a.on_cycle) ?
                                     node_rdata_a.dist_val : '0;
          ecount_nxt              = '0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      num_nodes_r <= NODE_W'(1);
      ecount_r    <= '0;
      eidx_r      <= '0;
      n_r         <= NC_W'(1);
      pass_r      <= '0;
      clr_r       <= '0;
      phase_r     <= 1'b0;
      changed_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ecount_r    <= ecount_nxt;
      eidx_r      <= eidx_nxt;
      n_r         <= n_nxt;
      pass_r      <= pass_nxt;
      clr_r       <= clr_nxt;
      phase_r     <= phase_nxt;
      changed_r   <= changed_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        num_nodes_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    sum_r <= sum_nxt;
    out_r <= out_nxt;
  end

  a_result_from_readout: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_RWAIT))
    else $error("result appeared without a target readout");

  a_cycle_zero_dist: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.positive_cycle) |-> (out_r.longest_distance == '0))
    else $error("distance reported for a node behind a positive cycle");

  a_no_node_write_in_load: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LOAD) |-> !node_we)
    else $error("node store written while loading edges");

  a_edge_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(ecount_r) <= MAX_EDGES)
    else $error("edge count beyond edge store depth");

endmodule

>>> verif/longest_path_bellman_ford_unit_test.sv
// ----------------------------------------------------------------------------
// longest_path_bellman_ford_unit_test
// Self-checking testbench for the longest-path Bellman-Ford unit. Edge
// requests are sent with random idling and random result stalls. Each graph
// is predicted in the testbench and each result is compared field by field.
// ----------------------------------------------------------------------------
module longest_path_bellman_ford_unit_test;
  import lpbf_pkg::*;

  localparam int NODE_CAP  = 1024;
  localparam int EDGE_CAP  = 64;
  localparam int QUIET_MAX = 2000000;
  localparam int EXP_DEPTH = 16;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  lpbf_in_t          in_data = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  lpbf_out_t         out_data;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [NODE_W-1:0] cfg_data = '0;

  // Testbench copy of the graph being loaded and of the node count.
  int        model_nodes = 1;
  int        graph_src[EDGE_CAP];
  int        graph_dst[EDGE_CAP];
  longint    graph_w[EDGE_CAP];
  int        graph_edges = 0;
  lpbf_out_t exp_paths[EXP_DEPTH];
  int        exp_wr = 0;
  int        exp_rd = 0;
  int        errors = 0;
  bit        idle_on = 1'b1;
  int        ostall_left = 0;
  int        quiet_cycles = 0;

  // A small edge store keeps the overflow test short.
  longest_path_bellman_ford_unit #(
    .MAX_NODES(NODE_CAP),
    .MAX_EDGES(EDGE_CAP)
  ) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic lpbf_out_t predict_longest_path();
    int        n;
    int        limit;
    int        a;
    int        b;
    bit        changed;
    longint    sum;
    longint    dist_val[NODE_CAP+1];
    bit        reached[NODE_CAP+1];
    bit        on_cycle[NODE_CAP+1];
    lpbf_out_t r;
    n = (model_nodes == 0) ? 1 : (model_nodes > NODE_CAP ? NODE_CAP : model_nodes);
    for (int k = 0; k <= NODE_CAP; k++) begin
      dist_val[k] = 0;
      reached[k] = 1'b0;
      on_cycle[k] = 1'b0;
    end
    reached[1] = 1'b1;
    // Phase 0 maximizes distances; phase 1 marks nodes that still improve.
    for (int phase = 0; phase < 2; phase++) begin
      limit = phase ? n : n - 1;
      for (int p = 0; p < limit; p++) begin
        changed = 1'b0;
        for (int i = 0; i < graph_edges; i++) begin
          a = graph_src[i];
          b = graph_dst[i];
          if (a < 1 || a > n || b < 1 || b > n || !reached[a]) continue;
          sum = dist_val[a] + graph_w[i];
          if (!reached[b] || dist_val[b] < sum) begin
            dist_val[b] = sum;
            reached[b] = 1'b1;
            changed = 1'b1;
            if (phase == 1) on_cycle[b] = 1'b1;
          end
          if (phase == 1 && on_cycle[a]) on_cycle[b] = 1'b1;
        end
        if (phase == 0 && !changed) break;
      end
    end
    r.target_reached = reached[n];
    r.positive_cycle = on_cycle[n];
    r.longest_distance = (reached[n] && !on_cycle[n]) ? dist_val[n] : 64'sd0;
    return r;
  endfunction

  task automatic send_edge(input int src, input int dst, input int w, input bit last);
    lpbf_in_t req;
    req.edge_source = src[NODE_W-1:0];
    req.edge_dest   = dst[NODE_W-1:0];
    req.edge_weight = w;
    req.last_edge   = last;
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (graph_edges < EDGE_CAP) begin
      graph_src[graph_edges] = src & 32'h7FF;
      graph_dst[graph_edges] = dst & 32'h7FF;
      graph_w[graph_edges]   = longint'(w);
      graph_edges++;
    end
    if (last) begin
      exp_paths[exp_wr % EXP_DEPTH] = predict_longest_path();
      exp_wr++;
      graph_edges = 0;
    end
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
  endtask

  // Waits until every result is back, then lets the block settle.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (exp_wr != exp_rd) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_nodes(input int value);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data  <= value[NODE_W-1:0];
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    model_nodes = value & 32'h7FF;
  endtask

  task automatic test_single_node();
    set_nodes(1);
    send_edge(1, 1, 5, 1'b1);
    set_nodes(0);
    send_edge(1, 2, -7, 1'b1);
  endtask

  task automatic test_extremes();
    set_nodes(3);
    send_edge(1, 2, 32'sh7FFFFFFF, 1'b0);
    send_edge(2, 3, 32'sh7FFFFFFF, 1'b0);
    send_edge(0, 3, 100, 1'b0);
    send_edge(2047, 3, 100, 1'b0);
    send_edge(1, 1024, 5, 1'b1);
    send_edge(1, 3, 32'sh80000000, 1'b0);
    send_edge(1, 2, 32'sh80000000, 1'b0);
    send_edge(2, 3, 32'sh80000000, 1'b1);
  endtask

  task automatic test_positive_cycle();
    set_nodes(4);
    send_edge(1, 2, 1, 1'b0);
    send_edge(2, 3, 1, 1'b0);
    send_edge(3, 2, 1, 1'b0);
    send_edge(3, 4, 5, 1'b1);
    // A zero-weight cycle is not improving.
    send_edge(1, 2, 3, 1'b0);
    send_edge(2, 3, 0, 1'b0);
    send_edge(3, 2, 0, 1'b0);
    send_edge(3, 4, -2, 1'b1);
  endtask

  task automatic test_unreachable();
    set_nodes(5);
    send_edge(2, 5, 9, 1'b0);
    send_edge(1, 3, 4, 1'b1);
  endtask

  task automatic test_max_nodes();
    set_nodes(1024);
    send_edge(1, 1024, -3, 1'b0);
    send_edge(1, 512, 8, 1'b0);
    send_edge(512, 1024, 1, 1'b1);
    set_nodes(2047);
    send_edge(1, 1024, 77, 1'b1);
  endtask

  // More edges than the store holds; the dropped last edge still starts work.
  task automatic test_edge_overflow();
    set_nodes(2);
    for (int i = 0; i < EDGE_CAP + 3; i++)
      send_edge(1, (i < 10) ? 2 : 1, $urandom_range(0, 40) - 20, i == EDGE_CAP + 2);
  endtask

  task automatic test_random_graphs(input int graphs);
    int n;
    int edges;
    int src;
    int dst;
    int w;
    for (int g = 0; g < graphs; g++) begin
      if (g >= graphs - 30) idle_on = 1'b0;
      if (g % 4 == 0) begin
        n = $urandom_range(0, 9);
        if ($urandom_range(0, 30) == 0) n = $urandom_range(0, 2047);
        set_nodes(n);
      end
      n = (model_nodes == 0) ? 1 : (model_nodes > 8 ? 8 : model_nodes);
      edges = (model_nodes > 16) ? $urandom_range(1, 3) : $urandom_range(1, 9);
      for (int e = 0; e < edges; e++) begin
        if (e < n - 1 && $urandom_range(0, 2) != 0) begin
          src = e + 1;
          dst = e + 2;
        end else begin
          src = $urandom_range(1, n);
          dst = $urandom_range(1, n);
        end
        if ($urandom_range(0, 9) == 0) src = $urandom_range(0, 2047);
        if ($urandom_range(0, 9) == 0) dst = $urandom_range(0, 2047);
        w = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 40) - 20 : $urandom;
        send_edge(src, dst, w, e == edges - 1);
      end
    end
  endtask

  always @(posedge clk) begin
    if (!idle_on) begin
      out_stall <= 1'b0;
    end else if (ostall_left > 0) begin
      out_stall <= 1'b1;
      ostall_left--;
    end else if ($urandom_range(0, 4) == 0) begin
      out_stall <= 1'b1;
      ostall_left = $urandom_range(0, 2);
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    lpbf_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (exp_wr == exp_rd) begin
        $display("%0t unexpected result: expected none actual %p", $time, out_data);
        errors++;
      end else begin
        want = exp_paths[exp_rd % EXP_DEPTH];
        exp_rd++;
        if (out_data.longest_distance !== want.longest_distance) begin
          $display("%0t longest_distance: expected %0d actual %0d", $time,
                   want.longest_distance, out_data.longest_distance);
          errors++;
        end
        if (out_data.target_reached !== want.target_reached) begin
          $display("%0t target_reached: expected %0b actual %0b", $time,
                   want.target_reached, out_data.target_reached);
          errors++;
        end
        if (out_data.positive_cycle !== want.positive_cycle) begin
          $display("%0t positive_cycle: expected %0b actual %0b", $time,
                   want.positive_cycle, out_data.positive_cycle);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= QUIET_MAX) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_single_node();
    test_extremes();
    test_positive_cycle();
    test_unreachable();
    test_max_nodes();
    test_edge_overflow();
    test_random_graphs(215);
    wait_drained();
    repeat (20) @(posedge clk);
    if (errors == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
